FILE: hw/rtl/dmx_universe_store_with_channel_mods_macros.svh
// ----------------------------------------------------------------------------
// DMX node assertion macros
// Concurrent property wrappers, compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DMX_UNIVERSE_STORE_WITH_CHANNEL_MODS_MACROS_SVH
`define DMX_UNIVERSE_STORE_WITH_CHANNEL_MODS_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DMX_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DMX_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DMX_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define DMX_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// DMX node package
// Shared types, codes and defaults of the DMX universe store.
// ----------------------------------------------------------------------------
package dmx_pkg;

	localparam int DEF_SLOTS    = 512;
	localparam int DEF_MAX_MODS = 16;
	localparam int CMDQ_DEPTH   = 2;

	typedef enum logic [2:0] {
		ACT_WRMOD = 3'd0,
		ACT_HDR   = 3'd1,
		ACT_BYTE  = 3'd2,
		ACT_TICK  = 3'd3,
		ACT_READ  = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		OP_WRMOD,
		OP_HDR,
		OP_BYTE,
		OP_TICK,
		OP_READ,
		OP_NOP
	} cmd_op_t;

	typedef enum logic [2:0] {
		MOP_SET   = 3'd0,
		MOP_ADD   = 3'd1,
		MOP_SUB   = 3'd2,
		MOP_COPY  = 3'd3,
		MOP_ADDS  = 3'd4,
		MOP_SUBS  = 3'd5,
		MOP_NZADD = 3'd6,
		MOP_NZSUB = 3'd7
	} mop_t;

	typedef enum logic [2:0] {
		REG_UNIVERSE = 3'd0,
		REG_TIMEOUT  = 3'd1,
		REG_INTERVAL = 3'd2,
		REG_OUTEN    = 3'd3,
		REG_MODCNT   = 3'd4
	} reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MFETCH,
		ST_MLOAD,
		ST_MEXEC
	} exec_state_t;

	typedef struct packed {
		logic [14:0] universe;
		logic [15:0] timeout_ms;
		logic [9:0]  send_interval_ms;
		logic        output_enabled;
		logic [4:0]  mod_count;
	} cfg_t;

	typedef struct packed {
		cmd_op_t     op;
		logic        match;
		logic [9:0]  count;
		logic [7:0]  data;
		logic        slot_ok;
		logic [9:0]  slot;
		logic [3:0]  mslot;
		logic [9:0]  mtarget;
		logic [2:0]  mop;
		logic [9:0]  moperand;
	} cmd_t;

	typedef struct packed {
		logic [9:0] target;
		logic [2:0] op;
		logic [9:0] operand;
	} mod_entry_t;

	typedef struct packed {
		logic clearing;
		logic res_valid;
	} stat_t;

endpackage

FILE: hw/rtl/dmx_front.sv
// ----------------------------------------------------------------------------
// DMX front end
// Accepts input beats, decodes the action and classifies the packet header.
// ----------------------------------------------------------------------------
module dmx_front import dmx_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [14:0] packet_universe,
	input  logic [9:0]  channel_count,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  read_slot,
	input  logic [3:0]  mod_slot,
	input  logic [9:0]  mod_target,
	input  logic [2:0]  mod_op,
	input  logic [9:0]  mod_operand,
	input  logic [14:0] universe,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_ready
);

	localparam logic [9:0] SLOTS_W = 10'(SLOTS);

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  dec;
	logic  take;

	// decode one beat
	always_comb begin
		dec          = '0;
		dec.match    = (packet_universe == universe);
		dec.count    = (channel_count > SLOTS_W) ? SLOTS_W : channel_count;
		dec.data     = data_byte;
		dec.slot_ok  = (read_slot <= SLOTS_W);
		dec.slot     = read_slot;
		dec.mslot    = mod_slot;
		dec.mtarget  = mod_target;
		dec.mop      = mod_op;
		dec.moperand = mod_operand;
		unique case (act_t'(action))
			ACT_WRMOD: dec.op = OP_WRMOD;
			ACT_HDR:   dec.op = OP_HDR;
			ACT_BYTE:  dec.op = OP_BYTE;
			ACT_TICK:  dec.op = OP_TICK;
			ACT_READ:  dec.op = OP_READ;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign full      = valid_s1 && !cmd_ready;
	assign take      = push && !full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// hold the decoded beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule

FILE: hw/rtl/dmx_cmdq.sv
// ----------------------------------------------------------------------------
// DMX command queue
// Short queue between the front end and the executor.
// ----------------------------------------------------------------------------
module dmx_cmdq import dmx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t wr_cmd,
	input  logic wr_valid,
	output logic wr_ready,
	output cmd_t rd_cmd,
	output logic rd_valid,
	input  logic rd_take
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_W = CW'(CMDQ_DEPTH);
	localparam logic [PW-1:0] LAST_W  = PW'(CMDQ_DEPTH - 1);

	cmd_t          buf_q [CMDQ_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr;
	logic          rd;

	assign wr_ready = (cnt_q != DEPTH_W);
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = buf_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_take && rd_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == LAST_W) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == LAST_W) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wp_q] <= wr_cmd;
		end
	end

endmodule

FILE: hw/rtl/dmx_exec.sv
// ----------------------------------------------------------------------------
// DMX executor
// Owns the frame memory, modifier table, timers and the result register.
// ----------------------------------------------------------------------------
module dmx_exec import dmx_pkg::*; #(
	parameter int SLOTS    = DEF_SLOTS,
	parameter int MAX_MODS = DEF_MAX_MODS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] read_value,
	output logic       frame_send,
	output logic       timed_out,
	output stat_t      stat
);

	localparam int AW  = $clog2(SLOTS + 1);
	localparam int IW  = $clog2(MAX_MODS + 1);
	localparam int MIW = (MAX_MODS > 1) ? $clog2(MAX_MODS) : 1;
	localparam logic [9:0]    SLOTS_W = 10'(SLOTS);
	localparam logic [AW-1:0] CLR_END = AW'(SLOTS);

	exec_state_t state_q, state_d;

	logic [7:0]    frame_mem [SLOTS + 1];
	mod_entry_t    mod_tab [MAX_MODS];
	mod_entry_t    ent_q;

	logic [AW-1:0] clr_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] n_mods;
	logic          last_mod;
	logic [31:0]   now_q, next_q, dl_q;
	logic [9:0]    wpos_q, bl_q;
	logic          match_q;
	logic          src_oob_q;
	logic [7:0]    rd_a_q, rd_b_q;

	logic          res_valid_q;
	logic [7:0]    res_read_q;
	logic          res_send_q, res_tout_q;

	// tick arithmetic
	logic [31:0] now_n, next_n, inc;
	logic        s1, s2, tout_hit;

	// command classification
	logic        mods_go, byte_live, skip;

	// memory and result controls
	logic          we;
	logic [AW-1:0] wa, ra_a, ra_b;
	logic [7:0]    wd;
	logic          fin;
	logic [7:0]    fin_read;
	logic          fin_send, fin_tout;

	// modifier math
	logic [7:0]  cur, src, newv;
	logic [10:0] vsum, ssum;
	logic [31:0] mc32;
	logic [MIW+3:0] mslot_x;

	assign mc32     = 32'(cfg.mod_count);
	assign n_mods   = (mc32 > 32'(MAX_MODS)) ? IW'(MAX_MODS) : IW'(mc32);
	assign last_mod = (IW'(idx_q + 1'b1) == n_mods);
	assign mslot_x  = (MIW + 4)'(cmd.mslot);
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && !res_valid_q;

	assign now_n    = now_q + 32'd1;
	assign s1       = cfg.output_enabled && (now_n >= next_q);
	assign tout_hit = (dl_q != '0) && (now_n >= dl_q);
	assign s2       = tout_hit && cfg.output_enabled;
	assign inc      = (s1 && s2) ? {21'd0, cfg.send_interval_ms, 1'b0}
	                             : {22'd0, cfg.send_interval_ms};
	assign next_n   = next_q + ((s1 || s2) ? inc : 32'd0);

	assign byte_live = (bl_q != '0);
	assign mods_go   = ((cmd.op == OP_HDR) && cmd.match && (cmd.count == '0)) ||
	                   ((cmd.op == OP_BYTE) && byte_live && match_q && (bl_q == 10'd1));
	assign skip      = (ent_q.target > SLOTS_W);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_END) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_take) begin
					if (mods_go && (n_mods != '0)) state_d = ST_MFETCH;
					else if ((cmd.op == OP_TICK) && tout_hit) state_d = ST_CLEAR;
					else if ((cmd.op == OP_READ) && cmd.slot_ok) state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_MFETCH: state_d = ST_MLOAD;
			ST_MLOAD: begin
				if (!skip) state_d = ST_MEXEC;
				else state_d = last_mod ? ST_IDLE : ST_MFETCH;
			end
			ST_MEXEC:  state_d = last_mod ? ST_IDLE : ST_MFETCH;
			default:   state_d = ST_IDLE;
		endcase
	end

	// modifier result
	always_comb begin
		cur  = rd_a_q;
		src  = src_oob_q ? 8'd0 : rd_b_q;
		vsum = {3'd0, cur} + {1'b0, ent_q.operand};
		ssum = {3'd0, cur} + {3'd0, src};
		newv = cur;
		unique case (mop_t'(ent_q.op))
			MOP_SET:  newv = ent_q.operand[7:0];
			MOP_ADD:  newv = (vsum > 11'd255) ? 8'hFF : vsum[7:0];
			MOP_SUB:  newv = ({2'd0, cur} < ent_q.operand) ? 8'd0
			                 : 8'(cur - ent_q.operand[7:0]);
			MOP_COPY: newv = src;
			MOP_ADDS: newv = (ssum > 11'd255) ? 8'hFF : ssum[7:0];
			MOP_SUBS: newv = (cur < src) ? 8'd0 : 8'(cur - src);
			MOP_NZADD: begin
				if (cur != '0) newv = (vsum > 11'd255) ? 8'hFF : vsum[7:0];
			end
			MOP_NZSUB: begin
				if (cur != '0) newv = ({2'd0, cur} < ent_q.operand) ? 8'd0
				                      : 8'(cur - ent_q.operand[7:0]);
			end
		endcase
	end

	// memory controls and result strobes
	always_comb begin
		we       = 1'b0;
		wa       = clr_q;
		wd       = 8'd0;
		ra_a     = cmd.slot[AW-1:0];
		ra_b     = '0;
		fin      = 1'b0;
		fin_read = 8'd0;
		fin_send = 1'b0;
		fin_tout = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				if (cmd_take) begin
					fin = !(mods_go && (n_mods != '0)) &&
					      !((cmd.op == OP_READ) && cmd.slot_ok);
					if ((cmd.op == OP_BYTE) && byte_live && match_q &&
					    (wpos_q <= SLOTS_W)) begin
						we = 1'b1;
						wa = wpos_q[AW-1:0];
						wd = cmd.data;
					end
					if (cmd.op == OP_TICK) begin
						fin_send = s1 || s2;
						fin_tout = tout_hit;
					end
				end
			end
			ST_READ: begin
				fin      = 1'b1;
				fin_read = rd_a_q;
			end
			ST_MFETCH: begin
			end
			ST_MLOAD: begin
				ra_a = ent_q.target[AW-1:0];
				ra_b = (ent_q.operand <= SLOTS_W) ? ent_q.operand[AW-1:0] : '0;
				fin  = skip && last_mod;
			end
			ST_MEXEC: begin
				we  = 1'b1;
				wa  = ent_q.target[AW-1:0];
				wd  = newv;
				fin = last_mod;
			end
			default: begin
			end
		endcase
	end

	// frame memory and modifier table
	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem[wa] <= wd;
		end
		rd_a_q <= frame_mem[ra_a];
		rd_b_q <= frame_mem[ra_b];
		if (cmd_take && (cmd.op == OP_WRMOD) && (32'(cmd.mslot) < 32'(MAX_MODS))) begin
			mod_tab[mslot_x[MIW-1:0]] <= '{target: cmd.mtarget, op: cmd.mop,
			                               operand: cmd.moperand};
		end
		ent_q <= mod_tab[idx_q[MIW-1:0]];
		if (state_q == ST_MLOAD) begin
			src_oob_q <= (ent_q.operand > SLOTS_W);
		end
		if (fin) begin
			res_read_q <= fin_read;
			res_send_q <= fin_send;
			res_tout_q <= fin_tout;
		end
	end

	// control state, timers and packet position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			now_q       <= '0;
			next_q      <= '0;
			dl_q        <= '0;
			wpos_q      <= 10'd1;
			bl_q        <= '0;
			match_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == CLR_END) ? '0 : clr_q + 1'b1;
			end
			if (cmd_take && mods_go) begin
				idx_q <= '0;
			end else if (((state_q == ST_MLOAD) && skip) || (state_q == ST_MEXEC)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd_take) begin
				unique case (cmd.op)
					OP_HDR: begin
						if (cfg.timeout_ms != '0) dl_q <= now_q + {16'd0, cfg.timeout_ms};
						match_q <= cmd.match;
						bl_q    <= cmd.count;
						wpos_q  <= 10'd1;
					end
					OP_BYTE: begin
						if (byte_live) begin
							bl_q   <= bl_q - 1'b1;
							wpos_q <= wpos_q + 1'b1;
						end
					end
					OP_TICK: begin
						now_q  <= now_n;
						next_q <= next_n;
						if (tout_hit) dl_q <= '0;
					end
					OP_WRMOD, OP_READ, OP_NOP: begin
					end
					default: begin
					end
				endcase
			end
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty          = !res_valid_q;
	assign read_value     = res_read_q;
	assign frame_send     = res_send_q;
	assign timed_out      = res_tout_q;
	assign stat.clearing  = (state_q == ST_CLEAR);
	assign stat.res_valid = res_valid_q;

endmodule

FILE: hw/rtl/dmx_universe_store_with_channel_mods.sv
// ----------------------------------------------------------------------------
// DMX universe store with channel modifiers
// Frame store, modifier pass and send/timeout scheduling of a DMX node.
// ----------------------------------------------------------------------------
// Every beat yields exactly one result. Writes, headers, ticks and bytes that
// finish nothing are done from the idle state, slot reads pass a read state.
// The last byte of a matching packet (or a matching header with no channels)
// runs the modifier pass, fetch and load per skipped entry and fetch, load and
// execute per applied entry, through the single frame memory. After reset and
// after each timeout the executor sweeps the frame to zero, one slot per cycle;
// beats queue meanwhile and configuration writes are taken as usual. A two-entry
// command queue lets the front end keep taking beats while the executor works.
`include "dmx_universe_store_with_channel_mods_macros.svh"

module dmx_universe_store_with_channel_mods import dmx_pkg::*; #(
	parameter int SLOTS    = DEF_SLOTS,
	parameter int MAX_MODS = DEF_MAX_MODS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [14:0] packet_universe,
	input  logic [9:0]  channel_count,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  read_slot,
	input  logic [3:0]  mod_slot,
	input  logic [9:0]  mod_target,
	input  logic [2:0]  mod_op,
	input  logic [9:0]  mod_operand,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  read_value,
	output logic        frame_send,
	output logic        timed_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	cmd_t  f_cmd, q_cmd;
	logic  f_valid, q_ready, q_valid, q_take;
	stat_t stat;
	logic  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.universe         <= '0;
			cfg_q.timeout_ms       <= '0;
			cfg_q.send_interval_ms <= 10'd23;
			cfg_q.output_enabled   <= 1'b1;
			cfg_q.mod_count        <= '0;
		end else if (cfg_wr) begin
			unique case (reg_t'(paddr[4:2]))
				REG_UNIVERSE: cfg_q.universe         <= pwdata[14:0];
				REG_TIMEOUT:  cfg_q.timeout_ms       <= pwdata[15:0];
				REG_INTERVAL: cfg_q.send_interval_ms <= pwdata[9:0];
				REG_OUTEN:    cfg_q.output_enabled   <= pwdata[0];
				REG_MODCNT:   cfg_q.mod_count        <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_t'(paddr[4:2]))
			REG_UNIVERSE: prdata = {17'd0, cfg_q.universe};
			REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout_ms};
			REG_INTERVAL: prdata = {22'd0, cfg_q.send_interval_ms};
			REG_OUTEN:    prdata = {31'd0, cfg_q.output_enabled};
			REG_MODCNT:   prdata = {27'd0, cfg_q.mod_count};
			default:      prdata = 32'd0;
		endcase
	end

	dmx_front #(.SLOTS(SLOTS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.action          (action),
		.packet_universe (packet_universe),
		.channel_count   (channel_count),
		.data_byte       (data_byte),
		.read_slot       (read_slot),
		.mod_slot        (mod_slot),
		.mod_target      (mod_target),
		.mod_op          (mod_op),
		.mod_operand     (mod_operand),
		.universe        (cfg_q.universe),
		.cmd             (f_cmd),
		.cmd_valid       (f_valid),
		.cmd_ready       (q_ready)
	);

	dmx_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (f_cmd),
		.wr_valid (f_valid),
		.wr_ready (q_ready),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid),
		.rd_take  (q_take)
	);

	dmx_exec #(.SLOTS(SLOTS), .MAX_MODS(MAX_MODS)) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (q_cmd),
		.cmd_valid  (q_valid),
		.cmd_take   (q_take),
		.empty      (empty),
		.pop        (pop),
		.read_value (read_value),
		.frame_send (frame_send),
		.timed_out  (timed_out),
		.stat       (stat)
	);

	`DMX_ASSERT_IMP(a_tout_no_read, clk, arst_n, !empty && timed_out, read_value == 8'd0, "timeout beat carries read data")
	`DMX_ASSERT_IMP(a_clear_after_tout, clk, arst_n, $rose(stat.clearing), stat.res_valid && timed_out, "frame sweep started without a timeout result")
	`DMX_ASSERT_NXT(a_no_take_clear, clk, arst_n, stat.clearing && !$rose(stat.clearing), !$rose(stat.res_valid) || !stat.clearing, "result produced during frame sweep")

endmodule

FILE: sim/tb_dmx_universe_store_with_channel_mods.sv
// ----------------------------------------------------------------------------
// DMX universe store testbench
// Drives beats through the input queue, predicts each status beat with an
// in-bench model of the frame store, modifier pass and tick scheduling, and
// compares every popped beat field by field. Registers go through APB.
// ----------------------------------------------------------------------------
module tb_dmx_universe_store_with_channel_mods;
	import dmx_pkg::*;

	localparam int NSLOTS   = 512;
	localparam int NMODS    = 16;
	localparam int LIMIT    = 2000000;
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]  action;
		logic [14:0] uni;
		logic [9:0]  count;
		logic [7:0]  data;
		logic [9:0]  rslot;
		logic [3:0]  mslot;
		logic [9:0]  mtarget;
		logic [2:0]  mop;
		logic [9:0]  moperand;
	} beat_t;

	typedef struct {
		logic [7:0] value;
		logic       send;
		logic       tout;
	} status_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic [2:0]  action = '0;
	logic [14:0] packet_universe = '0;
	logic [9:0]  channel_count = '0;
	logic [7:0]  data_byte = '0;
	logic [9:0]  read_slot = '0;
	logic [3:0]  mod_slot = '0;
	logic [9:0]  mod_target = '0;
	logic [2:0]  mod_op = '0;
	logic [9:0]  mod_operand = '0;
	logic        empty;
	logic        pop = 0;
	logic [7:0]  read_value;
	logic        frame_send;
	logic        timed_out;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// node image
	logic [7:0]  frame_img [0:NSLOTS];
	mod_entry_t  mod_img [0:NMODS-1];
	cfg_t        cfg_img;
	logic [31:0] now_img, next_send_img, deadline_img;
	int unsigned wpos_img, left_img;
	bit          matched_img;

	status_t     awaited_status [$];
	int          errors = 0;
	int          cycles = 0;
	bit          calm = 0;

	dmx_universe_store_with_channel_mods dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic logic [7:0] slot_of(logic [9:0] s);
		return (s <= NSLOTS) ? frame_img[s] : 8'd0;
	endfunction

	function automatic logic [7:0] add_sat(int unsigned a, int unsigned b);
		return (a + b > 255) ? 8'd255 : 8'(a + b);
	endfunction

	function automatic logic [7:0] sub_sat(int unsigned a, int unsigned b);
		return (a < b) ? 8'd0 : 8'(a - b);
	endfunction

	function automatic bit take_send();
		if (!cfg_img.output_enabled)
			return 0;
		next_send_img += 32'(cfg_img.send_interval_ms);
		return 1;
	endfunction

	// walk the modifier table over the frame, in entry order
	function automatic void run_modifiers();
		int unsigned n;
		logic [9:0] t;
		logic [9:0] v;
		logic [7:0] cur;
		n = (cfg_img.mod_count > NMODS) ? NMODS : cfg_img.mod_count;
		for (int i = 0; i < n; i++) begin
			t = mod_img[i].target;
			v = mod_img[i].operand;
			if (t > NSLOTS)
				continue;
			cur = frame_img[t];
			case (mop_t'(mod_img[i].op))
				MOP_SET:   frame_img[t] = v[7:0];
				MOP_ADD:   frame_img[t] = add_sat(cur, v);
				MOP_SUB:   frame_img[t] = sub_sat(cur, v);
				MOP_COPY:  frame_img[t] = slot_of(v);
				MOP_ADDS:  frame_img[t] = add_sat(cur, slot_of(v));
				MOP_SUBS:  frame_img[t] = sub_sat(cur, slot_of(v));
				MOP_NZADD: if (cur != 0) frame_img[t] = add_sat(cur, v);
				MOP_NZSUB: if (cur != 0) frame_img[t] = sub_sat(cur, v);
			endcase
		end
	endfunction

	// advance the node image by one accepted beat and queue its status
	function automatic void node_step(beat_t b);
		status_t s;
		s = '{default: '0};
		case (b.action)
			ACT_WRMOD: mod_img[b.mslot] = {b.mtarget, b.mop, b.moperand};
			ACT_HDR: begin
				if (cfg_img.timeout_ms != 0)
					deadline_img = now_img + 32'(cfg_img.timeout_ms);
				matched_img = (b.uni == cfg_img.universe);
				left_img = (b.count > NSLOTS) ? NSLOTS : b.count;
				wpos_img = 1;
				if (matched_img && left_img == 0)
					run_modifiers();
			end
			ACT_BYTE: begin
				if (left_img != 0) begin
					if (matched_img && wpos_img <= NSLOTS)
						frame_img[wpos_img] = b.data;
					wpos_img++;
					left_img--;
					if (matched_img && left_img == 0)
						run_modifiers();
				end
			end
			ACT_TICK: begin
				now_img++;
				if (now_img >= next_send_img && take_send())
					s.send = 1;
				if (deadline_img != 0 && now_img >= deadline_img) begin
					deadline_img = 0;
					foreach (frame_img[i]) frame_img[i] = 0;
					s.tout = 1;
					if (take_send())
						s.send = 1;
				end
			end
			ACT_READ: s.value = slot_of(b.rslot);
			default: ;
		endcase
		awaited_status.push_back(s);
	endfunction

	// send one beat; push stays high on return so back-to-back beats stream
	task automatic send_beat(beat_t b);
		int gap;
		bit ok;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 14);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		action          <= b.action;
		packet_universe <= b.uni;
		channel_count   <= b.count;
		data_byte       <= b.data;
		read_slot       <= b.rslot;
		mod_slot        <= b.mslot;
		mod_target      <= b.mtarget;
		mod_op          <= b.mop;
		mod_operand     <= b.moperand;
		push            <= 1;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		node_step(b);
	endtask

	function automatic beat_t noise_beat(logic [2:0] act);
		beat_t b;
		b.action   = act;
		b.uni      = 15'($urandom);
		b.count    = 10'($urandom);
		b.data     = 8'($urandom);
		b.rslot    = 10'($urandom);
		b.mslot    = 4'($urandom);
		b.mtarget  = 10'($urandom);
		b.mop      = 3'($urandom);
		b.moperand = 10'($urandom);
		return b;
	endfunction

	task automatic send_header(logic [14:0] u, logic [9:0] n);
		beat_t b;
		b = noise_beat(ACT_HDR);
		b.uni = u;
		b.count = n;
		send_beat(b);
	endtask

	task automatic send_data(logic [7:0] d);
		beat_t b;
		b = noise_beat(ACT_BYTE);
		b.data = d;
		send_beat(b);
	endtask

	task automatic send_tick();
		send_beat(noise_beat(ACT_TICK));
	endtask

	task automatic send_read(logic [9:0] s);
		beat_t b;
		b = noise_beat(ACT_READ);
		b.rslot = s;
		send_beat(b);
	endtask

	task automatic send_mod(logic [3:0] m, logic [9:0] t, mop_t op, logic [9:0] v);
		beat_t b;
		b = noise_beat(ACT_WRMOD);
		b.mslot = m;
		b.mtarget = t;
		b.mop = op;
		b.moperand = v;
		send_beat(b);
	endtask

	// drain every status, then let the executor finish any frame sweep
	task automatic wait_drained();
		push <= 0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (NSLOTS + 16) @(posedge clk);
	endtask

	task automatic reg_write(reg_t r, logic [31:0] v);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= 5'(r) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		case (r)
			REG_UNIVERSE: cfg_img.universe = v[14:0];
			REG_TIMEOUT:  cfg_img.timeout_ms = v[15:0];
			REG_INTERVAL: cfg_img.send_interval_ms = v[9:0];
			REG_OUTEN:    cfg_img.output_enabled = v[0];
			REG_MODCNT:   cfg_img.mod_count = v[4:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [14:0] u, logic [15:0] tmo, logic [9:0] ivl,
			logic en, logic [4:0] mc);
		wait_drained();
		reg_write(REG_UNIVERSE, 32'(u));
		reg_write(REG_TIMEOUT, 32'(tmo));
		reg_write(REG_INTERVAL, 32'(ivl));
		reg_write(REG_OUTEN, 32'(en));
		reg_write(REG_MODCNT, 32'(mc));
	endtask

	// fill the whole table with every operation, saturation and skip case
	task automatic test_modifier_ops();
		set_config(15'h7fff, 16'd0, 10'd23, 1'b1, 5'd31);
		send_mod(4'd0, 10'd1, MOP_SET, 10'd300);
		send_mod(4'd1, 10'd2, MOP_ADD, 10'd1023);
		send_mod(4'd2, 10'd3, MOP_SUB, 10'd512);
		send_mod(4'd3, 10'd4, MOP_COPY, 10'd1023);
		send_mod(4'd4, 10'd5, MOP_COPY, 10'd1);
		send_mod(4'd5, 10'd5, MOP_ADDS, 10'd2);
		send_mod(4'd6, 10'd6, MOP_SUBS, 10'd5);
		send_mod(4'd7, 10'd7, MOP_NZADD, 10'd10);
		send_mod(4'd8, 10'd1, MOP_NZSUB, 10'd1);
		send_mod(4'd9, 10'd2, MOP_NZADD, 10'd0);
		send_mod(4'd10, 10'd1023, MOP_SET, 10'd99);
		send_mod(4'd11, 10'd0, MOP_SET, 10'd512);
		send_mod(4'd12, 10'd512, MOP_ADDS, 10'd1);
		send_mod(4'd13, 10'd3, MOP_SUBS, 10'd700);
		send_mod(4'd14, 10'd512, MOP_NZSUB, 10'd5);
		send_mod(4'd15, 10'd513, MOP_SET, 10'd1);
		send_header(15'h7fff, 10'd3);
		send_data(8'h00);
		send_data(8'hff);
		send_data(8'h80);
		send_read(10'd0);
		send_read(10'd1);
		send_read(10'd5);
		send_read(10'd512);
		send_read(10'd1023);
		// matching header with no channels reapplies the table at once
		send_header(15'h7fff, 10'd0);
		send_read(10'd1);
	endtask

	// mismatched universe, abandoned packet, stray bytes, spare actions
	task automatic test_packet_edges();
		set_config(15'd0, 16'd65535, 10'd1000, 1'b1, 5'd16);
		send_header(15'd1, 10'd2);
		send_data(8'h55);
		send_data(8'haa);
		send_read(10'd1);
		send_header(15'd0, 10'd1023);
		send_data(8'h12);
		send_data(8'h34);
		send_header(15'd0, 10'd1);
		send_data(8'h77);
		send_data(8'h99);
		send_read(10'd1);
		send_read(10'd2);
		for (logic [3:0] a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
			send_beat(noise_beat(a[2:0]));
	endtask

	// zero interval, disabled output and a timeout on the first tick after a header
	task automatic test_ticks();
		set_config(15'd0, 16'd1, 10'd0, 1'b1, 5'd0);
		send_tick();
		send_tick();
		send_header(15'd0, 10'd1);
		send_data(8'h42);
		send_tick();
		send_read(10'd1);
		set_config(15'd0, 16'd2, 10'd1, 1'b0, 5'd0);
		send_header(15'd5, 10'd0);
		send_tick();
		send_tick();
		send_tick();
	endtask

	// one packet that fills every slot, with surplus bytes after it
	task automatic test_full_frame();
		set_config(15'h2a5, 16'd0, 10'd1, 1'b1, 5'd16);
		send_header(15'h2a5, 10'd1023);
		for (int i = 0; i < NSLOTS + 2; i++)
			send_data(8'($urandom));
		send_read(10'd512);
		send_read(10'd1);
	endtask

	// mostly well formed packets with ticks, reads and table rewrites between
	task automatic run_traffic(int items);
		int done;
		int n;
		int sent;
		logic [14:0] u;
		done = 0;
		while (done < items) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					u = ($urandom_range(0, 6) != 0) ? cfg_img.universe : 15'($urandom);
					n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(0, 24);
					if (n > 40) n = $urandom_range(0, 1) ? 1023 : n;
					send_header(u, 10'(n));
					// cut a few packets short so the next header abandons them
					sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : n;
					if (sent > 30) sent = $urandom_range(0, 30);
					for (int i = 0; i < sent; i++)
						send_data($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1) * 255)
							: 8'($urandom));
					done += 1 + sent;
				end
				9, 10, 11, 12: begin
					n = $urandom_range(1, 5);
					repeat (n) send_tick();
					done += n;
				end
				13, 14, 15: begin
					send_read($urandom_range(0, 3) == 0 ? 10'($urandom)
						: 10'($urandom_range(0, 30)));
					done++;
				end
				16, 17: begin
					send_mod(4'($urandom), $urandom_range(0, 3) == 0 ? 10'($urandom)
						: 10'($urandom_range(0, 30)), mop_t'(3'($urandom)),
						$urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 30)));
					done++;
				end
				18: begin
					send_beat(noise_beat(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))));
					done++;
				end
				default: send_data(8'($urandom));
			endcase
		end
	endtask

	// status side: pop with random stalls and check each beat
	initial begin : status_side
		status_t got;
		status_t want;
		bit took;
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			took = arst_n && pop && !empty;
			got.value = read_value;
			got.send = frame_send;
			got.tout = timed_out;
			@(posedge clk);
			if (took) begin
				if (awaited_status.size() == 0) begin
					report_mismatch("unexpected status beat", 1, 0);
				end else begin
					want = awaited_status.pop_front();
					if (got.value !== want.value)
						report_mismatch("read_value", got.value, want.value);
					if (got.send !== want.send)
						report_mismatch("frame_send", got.send, want.send);
					if (got.tout !== want.tout)
						report_mismatch("timed_out", got.tout, want.tout);
				end
			end
			if (calm) begin
				pop <= 1;
			end else if (hold > 0) begin
				hold--;
				pop <= 0;
			end else if ($urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 14) - 1;
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	initial begin : stimulus
		foreach (frame_img[i]) frame_img[i] = 0;
		foreach (mod_img[i]) mod_img[i] = '0;
		cfg_img = '{universe: 15'd0, timeout_ms: 16'd0, send_interval_ms: 10'd23,
			output_enabled: 1'b1, mod_count: 5'd0};
		now_img = 0;
		next_send_img = 0;
		deadline_img = 0;
		wpos_img = 1;
		left_img = 0;
		matched_img = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_modifier_ops();
		test_packet_edges();
		test_ticks();

		set_config(15'($urandom), 16'd5, 10'd1, 1'b1, 5'd4);
		run_traffic(10);
		set_config(15'h7fff, 16'd0, 10'd1000, 1'b0, 5'd16);
		run_traffic(10);
		test_full_frame();
		set_config(15'd0, 16'd65535, 10'd7, 1'b1, 5'd0);
		run_traffic(10);
		set_config(15'($urandom), 16'd3, 10'd2, 1'b1, 5'd8);
		calm = 1;
		run_traffic(10);

		push <= 0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
